>>> src/maf_pkg.sv
// shared types and constants for the moving average filter
package maf_pkg;

	localparam int SampleBits = 24;
	localparam int ValueBits  = SampleBits + 1;
	localparam int HistDepth  = 256;
	localparam int HistAddrBits = 8;
	localparam int LenBits    = 9;
	localparam int FracBits   = 16;
	localparam int WeightBits = FracBits + 1;
	localparam int SumBits    = SampleBits + LenBits + 1;
	localparam int EmaBits    = SampleBits + FracBits + 2;

	// configuration register indexes
	localparam logic [1:0] RegMethod = 2'd0;
	localparam logic [1:0] RegWindow = 2'd1;
	localparam logic [1:0] RegWeight = 2'd2;
	localparam logic [1:0] RegLag    = 2'd3;

	// method codes
	localparam logic [1:0] MethodSma  = 2'd0;
	localparam logic [1:0] MethodEma  = 2'd1;
	localparam logic [1:0] MethodDiff = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_LAG,
		ST_DIV,
		ST_DONE
	} state_t;

	// request from the sequencer to the divider
	typedef struct packed {
		logic                start;
		logic [SumBits-1:0]  dividend;
		logic [LenBits-1:0]  divisor;
	} div_req_t;

	// divider status
	typedef struct packed {
		logic                busy;
		logic                done;
		logic [SumBits-1:0]  quotient;
	} div_rsp_t;

endpackage

>>> src/maf_div.sv
// serial restoring divider, one quotient bit per cycle, signed dividend
module maf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  maf_pkg::div_req_t  req,
	output maf_pkg::div_rsp_t  rsp
);
	localparam int SB = maf_pkg::SumBits;
	localparam int LB = maf_pkg::LenBits;

	logic [SB-1:0] quo_q;
	logic [LB:0]   rem_q;
	logic [LB-1:0] den_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [LB:0]   trial;
	logic [LB:0]   shifted;

	// one restoring step
	always_comb begin
		shifted = {rem_q[LB-1:0], quo_q[SB-1]};
		trial   = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(SB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SB-1];
			quo_q <= req.dividend[SB-1] ? (~req.dividend + SB'(1)) : req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[LB]) begin
				rem_q <= trial;
				quo_q <= {quo_q[SB-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[SB-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + SB'(1)) : quo_q;
endmodule

>>> src/maf_ema.sv
// exponential average state, updated with one multiply per item
module maf_ema (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                update,
	input  logic signed [maf_pkg::SampleBits-1:0] x,
	input  logic [maf_pkg::WeightBits-1:0]      weight,
	output logic                                started,
	output logic signed [maf_pkg::ValueBits-1:0] avg
);
	localparam int EB = maf_pkg::EmaBits;
	localparam int FB = maf_pkg::FracBits;
	localparam int WB = maf_pkg::WeightBits;

	logic signed [EB-1:0] s_q;
	logic                 started_q;
	logic signed [EB-1:0] xs;
	logic signed [EB:0]   d;
	logic signed [EB+WB+1:0] prod;
	logic signed [EB-1:0] step;

	// weight times difference, floored
	always_comb begin
		xs   = EB'(x) <<< FB;
		d    = (EB+1)'(xs) - (EB+1)'(s_q);
		prod = (EB+WB+2)'(d) * $signed({1'b0, weight});
		step = EB'(prod >>> FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q       <= '0;
			started_q <= 1'b0;
		end else if (update) begin
			started_q <= 1'b1;
			s_q       <= started_q ? s_q + step : xs;
		end
	end

	assign started = started_q;
	assign avg     = maf_pkg::ValueBits'(s_q >>> FB);
endmodule

>>> src/moving_average_filter.sv
// Moving average filter top level: one result per sample in simple average,
// exponential average or lag difference mode. After reset the 256-entry
// history is swept to missing before the first sample is taken.
// An item takes window-1 history reads through the single memory port, one lag
// read, and a 34-step serial division that holds the sequencer; the next
// sample is accepted once the result has left the output register.
module moving_average_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [23:0] sample,
	input  logic        sample_present,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [24:0] value,
	output logic        defined
);
	localparam int SB = maf_pkg::SumBits;
	localparam int AB = maf_pkg::HistAddrBits;
	localparam int LB = maf_pkg::LenBits;

	logic [1:0]  method_q;
	logic [LB-1:0] window_q;
	logic [maf_pkg::WeightBits-1:0] weight_q;
	logic [LB-1:0] lag_q;

	maf_pkg::state_t state_q, state_d;

	// history memory, entry holds present bit and sample
	logic [maf_pkg::SampleBits:0] mem [maf_pkg::HistDepth];
	logic [maf_pkg::SampleBits:0] rd_q;
	logic [AB-1:0] rd_addr;
	logic          mem_we;
	logic [AB-1:0] wr_addr;
	logic [maf_pkg::SampleBits:0] wr_data;

	logic [AB-1:0] wpos_q;
	logic [AB-1:0] clr_q;
	logic [LB-1:0] k_q;
	logic [LB-1:0] win_len, lag_len;
	logic signed [maf_pkg::SampleBits-1:0] x_q;
	logic          pres_q;
	logic [SB-1:0] sum_q;
	logic [LB-1:0] cnt_q;
	logic          rd_valid_q;
	logic signed [maf_pkg::ValueBits-1:0] diff_q;
	logic          diff_def_q;
	logic signed [maf_pkg::ValueBits-1:0] value_q;
	logic          defined_q;
	logic          out_valid_q;
	logic          accept;
	logic          ema_started;
	logic signed [maf_pkg::ValueBits-1:0] ema_avg;
	maf_pkg::div_req_t div_req;
	maf_pkg::div_rsp_t div_rsp;

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != maf_pkg::ST_IDLE) || out_valid_q;

	// clamp lengths to 1..depth
	always_comb begin
		win_len = (window_q == '0) ? LB'(1) :
			(window_q > LB'(maf_pkg::HistDepth)) ? LB'(maf_pkg::HistDepth) : window_q;
		lag_len = (lag_q == '0) ? LB'(1) :
			(lag_q > LB'(maf_pkg::HistDepth)) ? LB'(maf_pkg::HistDepth) : lag_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= maf_pkg::MethodSma;
			window_q <= LB'(1);
			weight_q <= maf_pkg::WeightBits'(1 << maf_pkg::FracBits);
			lag_q    <= LB'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				maf_pkg::RegMethod: method_q <= cfg_data[1:0];
				maf_pkg::RegWindow: window_q <= cfg_data[LB-1:0];
				maf_pkg::RegWeight: begin
					if (cfg_data[maf_pkg::WeightBits-1:0] == '0)
						weight_q <= maf_pkg::WeightBits'(1);
					else if (cfg_data[maf_pkg::WeightBits-1:0] >
						maf_pkg::WeightBits'(1 << maf_pkg::FracBits))
						weight_q <= maf_pkg::WeightBits'(1 << maf_pkg::FracBits);
					else
						weight_q <= cfg_data[maf_pkg::WeightBits-1:0];
				end
				maf_pkg::RegLag: lag_q <= cfg_data[LB-1:0];
				default: ;
			endcase
		end
	end

	// memory port addressing
	always_comb begin
		rd_addr = wpos_q - k_q[AB-1:0];
		mem_we  = 1'b0;
		wr_addr = wpos_q;
		wr_data = {pres_q, x_q};
		if (state_q == maf_pkg::ST_CLEAR) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == maf_pkg::ST_DONE) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			maf_pkg::ST_CLEAR: if (clr_q == '1) state_d = maf_pkg::ST_IDLE;
			maf_pkg::ST_IDLE:  if (accept) state_d = maf_pkg::ST_SCAN;
			maf_pkg::ST_SCAN:  if (k_q >= win_len) state_d = maf_pkg::ST_SCAN_LAST;
			maf_pkg::ST_SCAN_LAST: state_d = maf_pkg::ST_LAG;
			maf_pkg::ST_LAG:   state_d = maf_pkg::ST_DIV;
			maf_pkg::ST_DIV:   if (div_rsp.done) state_d = maf_pkg::ST_DONE;
			maf_pkg::ST_DONE:  state_d = maf_pkg::ST_IDLE;
			default:           state_d = maf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= maf_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			wpos_q      <= '0;
			k_q         <= '0;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == maf_pkg::ST_CLEAR) clr_q <= clr_q + AB'(1);
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			rd_valid_q <= 1'b0;
			unique case (state_q)
				maf_pkg::ST_IDLE: if (accept) k_q <= LB'(1);
				maf_pkg::ST_SCAN: begin
					rd_valid_q <= (k_q < win_len);
					if (k_q >= win_len) k_q <= lag_len;
					else                k_q <= k_q + LB'(1);
				end
				maf_pkg::ST_DONE: begin
					wpos_q      <= wpos_q + AB'(1);
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// accumulation, lag difference and result
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample;
			pres_q <= sample_present;
			sum_q  <= sample_present ? SB'(sample) : '0;
			cnt_q  <= sample_present ? LB'(1) : '0;
		end
		if (rd_valid_q && rd_q[maf_pkg::SampleBits]) begin
			sum_q <= sum_q + SB'($signed(rd_q[maf_pkg::SampleBits-1:0]));
			cnt_q <= cnt_q + LB'(1);
		end
		if (state_q == maf_pkg::ST_LAG) begin
			diff_def_q <= pres_q && rd_q[maf_pkg::SampleBits];
			diff_q <= maf_pkg::ValueBits'(x_q) -
				maf_pkg::ValueBits'($signed(rd_q[maf_pkg::SampleBits-1:0]));
		end
		if (state_q == maf_pkg::ST_DONE) begin
			unique case (method_q)
				maf_pkg::MethodSma: begin
					defined_q <= cnt_q != '0;
					value_q   <= (cnt_q != '0) ? maf_pkg::ValueBits'(div_rsp.quotient) : '0;
				end
				maf_pkg::MethodEma: begin
					defined_q <= ema_started;
					value_q   <= ema_started ? ema_avg : '0;
				end
				maf_pkg::MethodDiff: begin
					defined_q <= diff_def_q;
					value_q   <= diff_def_q ? diff_q : '0;
				end
				default: begin
					defined_q <= 1'b0;
					value_q   <= '0;
				end
			endcase
		end
	end

	// divider request once the sum is final
	always_comb begin
		div_req.start    = (state_q == maf_pkg::ST_LAG);
		div_req.dividend = sum_q;
		div_req.divisor  = (cnt_q == '0) ? LB'(1) : cnt_q;
	end

	maf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// exponential state moves ahead of the result so the current sample is included
	maf_ema u_ema (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  ((state_q == maf_pkg::ST_LAG) && pres_q),
		.x       (x_q),
		.weight  (weight_q),
		.started (ema_started),
		.avg     (ema_avg)
	);

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign defined   = defined_q;

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == maf_pkg::ST_IDLE && !out_valid_q)
		else $error("sample accepted while busy");
	a_div_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == maf_pkg::ST_DONE |-> !div_rsp.busy)
		else $error("result formed while divider busy");
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == maf_pkg::ST_DONE)
		else $error("result without completed item");
endmodule
